@@ hw/rtl/mxs_pkg.sv @@
// package for the max stack: cell command and data types, opcodes, status codes
package mxs_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_WIDTH   = 32;

   typedef enum logic [2:0] {
      OP_PUSH     = 3'd0,
      OP_POP      = 3'd1,
      OP_TOP      = 3'd2,
      OP_PEEK_MAX = 3'd3,
      OP_POP_MAX  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_POP  = 2'd2,
      CELL_ROT  = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      logic                           valid;
      logic signed [VALUE_WIDTH-1:0]  value;
      logic signed [VALUE_WIDTH-1:0]  max_value;
   } cell_data_type;

endpackage

@@ hw/rtl/max_stack_core.sv @@
// max stack top level: command sequencer over a row of stack cells
//
//  channel  ports                                  handshake
//  request  req_opcode, req_push_value             start high while busy low
//  result   rsp_result_value, rsp_status           rsp_strobe high for one cycle
//
//  push, pop, top, peek max: busy stays low; the result is registered, in the cycle after the request beat
//  pop max: the cell row rotates until the largest entry reaches the top, drops it,
//  rotates on in the same direction until the old order returns, then the running
//  maxima ripple up one cell per cycle
//  reset empties the stack; the result beat cannot be stalled
module max_stack_core #(
   parameter int DEPTH = mxs_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic signed [31:0] req_push_value,
   output logic        rsp_strobe,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]  rsp_status
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEEK,
      ST_UNROT,
      ST_SETTLE
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            fill_ff, fill_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic signed [31:0]       target_ff, target_in;
   logic                     strobe_ff, strobe_in;
   logic signed [31:0]       result_ff, result_in;
   logic [1:0]               status_ff, status_in;

   mxs_pkg::cell_cmd_type    cmd;
   mxs_pkg::cell_data_type   head_in;
   mxs_pkg::cell_data_type   head;
   logic                     accept;
   logic                     full;
   logic                     empty;

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = (fill_ff == CW'(DEPTH));
   assign empty  = (fill_ff == '0);

   always_comb begin
      head_in.valid = 1'b1;
      head_in.value = req_push_value;
      if (!head.valid || (req_push_value > head.max_value)) begin
         head_in.max_value = req_push_value;
      end else begin
         head_in.max_value = head.max_value;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      target_in = target_ff;
      strobe_in = 1'b0;
      result_in = result_ff;
      status_in = status_ff;
      cmd       = mxs_pkg::CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               strobe_in = 1'b1;
               result_in = '0;
               status_in = mxs_pkg::STATUS_OK;
               case (req_opcode)
                  mxs_pkg::OP_PUSH: begin
                     if (full) begin
                        status_in = mxs_pkg::STATUS_FULL;
                     end else begin
                        cmd     = mxs_pkg::CELL_PUSH;
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  mxs_pkg::OP_POP: begin
                     if (empty) begin
                        status_in = mxs_pkg::STATUS_EMPTY;
                     end else begin
                        result_in = head.value;
                        cmd       = mxs_pkg::CELL_POP;
                        fill_in   = fill_ff - CW'(1);
                     end
                  end
                  mxs_pkg::OP_TOP: begin
                     if (empty) begin
                        status_in = mxs_pkg::STATUS_EMPTY;
                     end else begin
                        result_in = head.value;
                     end
                  end
                  mxs_pkg::OP_PEEK_MAX: begin
                     if (empty) begin
                        status_in = mxs_pkg::STATUS_EMPTY;
                     end else begin
                        result_in = head.max_value;
                     end
                  end
                  mxs_pkg::OP_POP_MAX: begin
                     if (empty) begin
                        status_in = mxs_pkg::STATUS_EMPTY;
                     end else begin
                        strobe_in = 1'b0;
                        target_in = head.max_value;
                        cnt_in    = fill_ff - CW'(1);
                        state_in  = ST_SEEK;
                     end
                  end
                  default: begin
                     status_in = mxs_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_SEEK: begin
            if (head.value == target_ff) begin
               // drop the top-most largest entry
               cmd       = mxs_pkg::CELL_POP;
               fill_in   = fill_ff - CW'(1);
               strobe_in = 1'b1;
               result_in = target_ff;
               status_in = mxs_pkg::STATUS_OK;
               if (cnt_ff == '0) begin
                  state_in = ST_SETTLE;
                  cnt_in   = (fill_ff < CW'(2)) ? '0 : fill_ff - CW'(2);
               end else begin
                  state_in = ST_UNROT;
               end
            end else begin
               cmd    = mxs_pkg::CELL_ROT;
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_UNROT: begin
            cmd    = mxs_pkg::CELL_ROT;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_SETTLE;
               cnt_in   = fill_ff - CW'(1);
            end
         end
         ST_SETTLE: begin
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
      target_ff <= target_in;
      result_ff <= result_in;
      status_ff <= status_in;
   end

   mxs_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .head_in (head_in),
      .head    (head)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_result_value = result_ff;
   assign rsp_status       = status_ff;

   // top cell holds an entry exactly when the stack is not empty
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != '0) == head.valid)
      else $error("head valid bit disagrees with fill count");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_pop_max_flow: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == mxs_pkg::OP_POP_MAX)) |=> (busy || rsp_strobe))
      else $error("pop max neither started nor answered");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == mxs_pkg::STATUS_EMPTY)) |-> (rsp_result_value == 0))
      else $error("empty status with nonzero value");

endmodule

@@ hw/rtl/mxs_cell.sv @@
// one stack cell: an entry, the maximum of it and all entries below, and a valid bit
module mxs_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mxs_pkg::cell_cmd_type  cmd,
   input  mxs_pkg::cell_data_type prev_data,
   input  mxs_pkg::cell_data_type next_data,
   input  logic signed [mxs_pkg::VALUE_WIDTH-1:0] wrap_value,
   output mxs_pkg::cell_data_type data
);

   logic                                  valid_ff, valid_in;
   logic signed [mxs_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic signed [mxs_pkg::VALUE_WIDTH-1:0] max_ff, max_in;
   logic signed [mxs_pkg::VALUE_WIDTH-1:0] next_max;
   logic signed [mxs_pkg::VALUE_WIDTH-1:0] next_value;

   assign next_max   = next_data.max_value;
   assign next_value = next_data.value;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      max_in   = max_ff;
      case (cmd)
         mxs_pkg::CELL_HOLD: begin
            if (next_data.valid && (next_max > value_ff)) begin
               max_in = next_max;
            end else begin
               max_in = value_ff;
            end
         end
         mxs_pkg::CELL_PUSH: begin
            valid_in = prev_data.valid;
            value_in = prev_data.value;
            max_in   = prev_data.max_value;
         end
         mxs_pkg::CELL_POP: begin
            valid_in = next_data.valid;
            value_in = next_value;
            max_in   = next_max;
         end
         mxs_pkg::CELL_ROT: begin
            // bottom entry takes the old top, the rest move up
            if (valid_ff && !next_data.valid) begin
               value_in = wrap_value;
            end else begin
               value_in = next_value;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      max_ff   <= max_in;
   end

   assign data.valid     = valid_ff;
   assign data.value     = value_ff;
   assign data.max_value = max_ff;

endmodule

@@ hw/rtl/mxs_chain.sv @@
// row of stack cells, top of stack in cell 0
module mxs_chain #(
   parameter int DEPTH = mxs_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mxs_pkg::cell_cmd_type  cmd,
   input  mxs_pkg::cell_data_type head_in,
   output mxs_pkg::cell_data_type head
);

   mxs_pkg::cell_data_type cell_data [DEPTH];
   mxs_pkg::cell_data_type tail_data;

   assign tail_data = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      mxs_pkg::cell_data_type prev_data;
      mxs_pkg::cell_data_type next_data;

      if (i == 0) begin : g_first
         assign prev_data = head_in;
      end else begin : g_mid
         assign prev_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_data = tail_data;
      end else begin : g_inner
         assign next_data = cell_data[i+1];
      end

      mxs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_data  (prev_data),
         .next_data  (next_data),
         .wrap_value (cell_data[0].value),
         .data       (cell_data[i])
      );
   end

   assign head = cell_data[0];

endmodule

@@ tb/tb_top.sv @@
// testbench for max_stack_core: directed and random opcode beats checked against a stack model
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH  = mxs_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_WAIT  = 4 * STACK_DEPTH + 20;
   localparam int RANDOM_BEATS = 900;
   localparam int REPORT_LIMIT = 10;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_MID   = 3'd6;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic signed [31:0] value;
      logic [1:0]         status;
   } stack_answer_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_opcode;
   logic signed [31:0] req_push_value;
   logic               rsp_strobe;
   logic signed [31:0] rsp_result_value;
   logic [1:0]         rsp_status;

   logic signed [31:0] model_entries [STACK_DEPTH];
   int                 model_fill = 0;
   stack_answer_type   answer_q [$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   logic               no_idle = 1'b0;

   max_stack_core #(
      .DEPTH (STACK_DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_push_value   (req_push_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // slot of the top-most largest entry; needs a non-empty stack
   function automatic int top_max_slot();
      int best;
      best = 0;
      for (int i = 1; i < model_fill; i++) begin
         if (model_entries[i] >= model_entries[best]) best = i;
      end
      return best;
   endfunction

   function automatic stack_answer_type apply_to_model(input logic [2:0] op,
                                                       input logic signed [31:0] val);
      stack_answer_type ans;
      int               k;
      ans.value  = '0;
      ans.status = mxs_pkg::STATUS_OK;
      case (op)
         mxs_pkg::OP_PUSH: begin
            if (model_fill >= STACK_DEPTH) begin
               ans.status = mxs_pkg::STATUS_FULL;
            end else begin
               model_entries[model_fill] = val;
               model_fill++;
            end
         end
         mxs_pkg::OP_POP, mxs_pkg::OP_TOP, mxs_pkg::OP_PEEK_MAX, mxs_pkg::OP_POP_MAX: begin
            if (model_fill == 0) begin
               ans.status = mxs_pkg::STATUS_EMPTY;
            end else if (op == mxs_pkg::OP_POP) begin
               model_fill--;
               ans.value = model_entries[model_fill];
            end else if (op == mxs_pkg::OP_TOP) begin
               ans.value = model_entries[model_fill - 1];
            end else if (op == mxs_pkg::OP_PEEK_MAX) begin
               ans.value = model_entries[top_max_slot()];
            end else begin
               k = top_max_slot();
               ans.value = model_entries[k];
               for (int i = k; i < model_fill - 1; i++) model_entries[i] = model_entries[i + 1];
               model_fill--;
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 98) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // small values give many equal maxima
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 30) begin
         return 32'(int'($urandom_range(6)) - 3);
      end else if (r < 40) begin
         case ($urandom_range(3))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_read_op();
      case ($urandom_range(3))
         0:       return mxs_pkg::OP_POP;
         1:       return mxs_pkg::OP_TOP;
         2:       return mxs_pkg::OP_PEEK_MAX;
         default: return mxs_pkg::OP_POP_MAX;
      endcase
   endfunction

   function void note_mismatch(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
   endfunction

   // entered and left at a falling edge; start stays high between back-to-back beats
   task automatic send_beat(input logic [2:0] op, input logic signed [31:0] val);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_push_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      answer_q = {answer_q, apply_to_model(op, val)};
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      stack_answer_type want;
      if (!reset && rsp_strobe) begin
         if (answer_q.size() == 0) begin
            note_mismatch("result beat with nothing pending, value", 32'sd0, rsp_result_value);
         end else begin
            want = answer_q.pop_front();
            if (rsp_result_value !== want.value)
               note_mismatch("result value", want.value, rsp_result_value);
            if (rsp_status !== want.status)
               note_mismatch("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_empty_stack();
      send_beat(mxs_pkg::OP_POP, $urandom);
      send_beat(mxs_pkg::OP_TOP, $urandom);
      send_beat(mxs_pkg::OP_PEEK_MAX, $urandom);
      send_beat(mxs_pkg::OP_POP_MAX, $urandom);
      send_beat(OP_SPARE_FIRST, 32'sh1234_5678);
      send_beat(OP_SPARE_MID, -32'sd1);
      send_beat(OP_SPARE_LAST, -32'sd1);
      send_beat(mxs_pkg::OP_PUSH, 32'sd7);
      send_beat(mxs_pkg::OP_POP, 32'sd0);
      send_beat(mxs_pkg::OP_POP_MAX, 32'sd0);
   endtask

   task automatic test_value_extremes();
      send_beat(mxs_pkg::OP_PUSH, VALUE_MIN);
      send_beat(mxs_pkg::OP_PUSH, VALUE_MAX);
      send_beat(mxs_pkg::OP_PUSH, -32'sd1);
      send_beat(mxs_pkg::OP_PUSH, 32'sd0);
      send_beat(mxs_pkg::OP_PUSH, VALUE_MAX);
      send_beat(mxs_pkg::OP_PUSH, 32'sd5);
      send_beat(mxs_pkg::OP_PEEK_MAX, 32'sd0);
      send_beat(mxs_pkg::OP_POP_MAX, 32'sd0);
      send_beat(mxs_pkg::OP_TOP, 32'sd0);
      send_beat(mxs_pkg::OP_POP_MAX, 32'sd0);
      send_beat(mxs_pkg::OP_PEEK_MAX, 32'sd0);
      send_beat(mxs_pkg::OP_POP, 32'sd0);
      send_beat(mxs_pkg::OP_POP_MAX, 32'sd0);
      send_beat(mxs_pkg::OP_POP, 32'sd0);
      send_beat(mxs_pkg::OP_TOP, 32'sd0);
   endtask

   task automatic test_full_stack();
      while (model_fill < STACK_DEPTH) send_beat(mxs_pkg::OP_PUSH, pick_value());
      repeat (3) send_beat(mxs_pkg::OP_PUSH, $urandom);
      send_beat(mxs_pkg::OP_TOP, 32'sd0);
      send_beat(mxs_pkg::OP_PEEK_MAX, 32'sd0);
      while (model_fill > 0) begin
         if ($urandom_range(4) == 0) send_beat(mxs_pkg::OP_PEEK_MAX, $urandom);
         send_beat(mxs_pkg::OP_POP_MAX, $urandom);
      end
   endtask

   task automatic test_random_mix();
      logic       fill_mode;
      logic [2:0] op;
      int         r;
      fill_mode = 1'b1;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 100 == 0) no_idle = ($urandom_range(3) == 0);
         if (fill_mode && model_fill >= STACK_DEPTH && $urandom_range(3) == 0) fill_mode = 1'b0;
         else if (!fill_mode && model_fill == 0 && $urandom_range(3) == 0) fill_mode = 1'b1;
         else if ($urandom_range(79) == 0) fill_mode = !fill_mode;
         r = $urandom_range(99);
         if (r < 3) op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         else if (r < (fill_mode ? 65 : 25)) op = mxs_pkg::OP_PUSH;
         else op = pick_read_op();
         send_beat(op, (op == mxs_pkg::OP_PUSH) ? pick_value() : $urandom);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = mxs_pkg::OP_PUSH;
      req_push_value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_stack();
      test_value_extremes();
      test_full_stack();
      test_random_mix();

      start <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
